// ===== src/nsc_pkg.sv =====
// Package for the sentence checker: word types, character and status codes, hex helper.
// No dependencies; used by every module of the block except nsc_queue.
`default_nettype none

package nsc_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GARBAGE_LIMIT = 8'd1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd10;
    localparam logic [7:0]  GARBAGE_RESET = 8'd100;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_C      = 8'h43;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic KIND_LINE    = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NO_DOLLAR   = 3'd1;
    localparam logic [2:0] ST_NO_STAR     = 3'd2;
    localparam logic [2:0] ST_MISMATCH    = 3'd3;
    localparam logic [2:0] ST_BAD_TERM    = 3'd4;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic       result_kind;
        logic [2:0] line_status;
        logic       compass_sentence;
        logic [7:0] computed_checksum;
        logic [7:0] invalid_run;
        logic       garbage_alarm;
    } out_word_t;

    typedef struct packed {
        logic       tick;
        logic       is_lf;
        logic       is_dollar;
        logic       is_star;
        logic       is_cr;
        logic       is_c;
        logic [7:0] data;
    } cls_word_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10)
            r = 8'h30 + {4'd0, nib};
        else
            r = 8'h41 + {4'd0, nib} - 8'd10;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/nsc_front.sv =====
// Front end: marks each incoming word as a tick or not and flags its byte against the framing characters and C.
// Depends on nsc_pkg.
`default_nettype none

module nsc_front (
    input  wire nsc_pkg::in_word_t  item,
    output nsc_pkg::cls_word_t      cls
);

    always_comb
    begin
        cls.tick      = (item.operation == nsc_pkg::OP_TICK);
        cls.is_lf     = (item.rx_byte == nsc_pkg::CH_LF);
        cls.is_dollar = (item.rx_byte == nsc_pkg::CH_DOLLAR);
        cls.is_star   = (item.rx_byte == nsc_pkg::CH_STAR);
        cls.is_cr     = (item.rx_byte == nsc_pkg::CH_CR);
        cls.is_c      = (item.rx_byte == nsc_pkg::CH_C);
        cls.data      = item.rx_byte;
    end

endmodule

`default_nettype wire

// ===== src/nsc_queue.sv =====
// Small register queue used between front and back and on the result side.
// No dependencies.
`default_nettype none

module nsc_queue #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 2
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              wr_en,
    input  wire [Width-1:0]  wr_data,
    output logic             full,
    input  wire              rd_en,
    output logic [Width-1:0] rd_data,
    output logic             empty
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    logic [Width-1:0] mem_reg [Depth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == FullCnt);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

// ===== src/nsc_back.sv =====
// Back end: line framing state, checksum, invalid-run counter, tick watchdog, config registers.
// Depends on nsc_pkg.
`default_nettype none

module nsc_back (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_valid,
    input  wire [nsc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire [nsc_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire                                  take,
    input  wire nsc_pkg::cls_word_t              cls,
    output logic                                 res_valid,
    output nsc_pkg::out_word_t                   res
);

    localparam logic [2:0] PH_WAIT    = 3'd0;
    localparam logic [2:0] PH_FIRST   = 3'd1;
    localparam logic [2:0] PH_BODY    = 3'd2;
    localparam logic [2:0] PH_HEX_HI  = 3'd3;
    localparam logic [2:0] PH_HEX_LO  = 3'd4;
    localparam logic [2:0] PH_TERM    = 3'd5;
    localparam logic [2:0] PH_AFTERCR = 3'd6;
    localparam logic [2:0] PH_SKIP    = 3'd7;

    localparam logic [16:0] ElapsedMax = 17'h1FFFF;
    localparam logic [7:0]  RunMax     = 8'hFF;

    logic [15:0] timeout_reg;
    logic [7:0]  limit_reg;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  xor_reg, xor_next;
    logic        first_c_reg, first_c_next;
    logic        mismatch_reg, mismatch_next;
    logic        term_bad_reg, term_bad_next;
    logic [7:0]  run_reg, run_next;
    logic [16:0] elapsed_reg, elapsed_next;
    logic        seen_reg, seen_next;
    logic        fired_reg, fired_next;
    logic [16:0] tick_limit;
    logic [2:0]  status;

    always_comb
    begin
        phase_next    = phase_reg;
        xor_next      = xor_reg;
        first_c_next  = first_c_reg;
        mismatch_next = mismatch_reg;
        term_bad_next = term_bad_reg;
        run_next      = run_reg;
        elapsed_next  = elapsed_reg;
        seen_next     = seen_reg;
        fired_next    = fired_reg;
        tick_limit    = seen_reg ? {1'b0, timeout_reg} : {timeout_reg, 1'b0};
        status        = nsc_pkg::ST_OK;
        res_valid     = 1'b0;
        res.result_kind       = nsc_pkg::KIND_LINE;
        res.line_status       = nsc_pkg::ST_OK;
        res.compass_sentence  = 1'b0;
        res.computed_checksum = 8'd0;

        if (take)
        begin
            if (cls.tick)
            begin
                if (timeout_reg != 16'd0 && !fired_reg)
                begin
                    if (elapsed_reg != ElapsedMax)
                        elapsed_next = elapsed_reg + 17'd1;
                    if (elapsed_next >= tick_limit)
                    begin
                        fired_next      = 1'b1;
                        res_valid       = 1'b1;
                        res.result_kind = nsc_pkg::KIND_TIMEOUT;
                    end
                end
            end
            else if (cls.is_lf)
            begin
                case (phase_reg)
                    PH_WAIT:            status = nsc_pkg::ST_NO_DOLLAR;
                    PH_FIRST, PH_BODY:  status = nsc_pkg::ST_NO_STAR;
                    PH_HEX_HI, PH_HEX_LO: status = nsc_pkg::ST_MISMATCH;
                    default:
                    begin
                        if (mismatch_reg)
                            status = nsc_pkg::ST_MISMATCH;
                        else if (term_bad_reg)
                            status = nsc_pkg::ST_BAD_TERM;
                        else
                            status = nsc_pkg::ST_OK;
                    end
                endcase
                if (status == nsc_pkg::ST_OK)
                begin
                    run_next     = 8'd0;
                    seen_next    = 1'b1;
                    elapsed_next = 17'd0;
                    fired_next   = 1'b0;
                    res.compass_sentence = first_c_reg;
                end
                else if (run_reg != RunMax)
                begin
                    run_next = run_reg + 8'd1;
                end
                res_valid             = 1'b1;
                res.line_status       = status;
                res.computed_checksum = (phase_reg == PH_WAIT) ? 8'd0 : xor_reg;
                phase_next    = PH_WAIT;
                xor_next      = 8'd0;
                first_c_next  = 1'b0;
                mismatch_next = 1'b0;
                term_bad_next = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_WAIT:
                    begin
                        if (cls.is_dollar)
                            phase_next = PH_FIRST;
                    end
                    PH_FIRST, PH_BODY:
                    begin
                        if (cls.is_star)
                        begin
                            phase_next = PH_HEX_HI;
                        end
                        else
                        begin
                            if (phase_reg == PH_FIRST && cls.is_c)
                                first_c_next = 1'b1;
                            xor_next   = xor_reg ^ cls.data;
                            phase_next = PH_BODY;
                        end
                    end
                    PH_HEX_HI:
                    begin
                        if (cls.data != nsc_pkg::hex_digit(xor_reg[7:4]))
                            mismatch_next = 1'b1;
                        phase_next = PH_HEX_LO;
                    end
                    PH_HEX_LO:
                    begin
                        if (cls.data != nsc_pkg::hex_digit(xor_reg[3:0]))
                            mismatch_next = 1'b1;
                        phase_next = PH_TERM;
                    end
                    PH_TERM:
                    begin
                        if (cls.is_cr)
                        begin
                            phase_next = PH_AFTERCR;
                        end
                        else
                        begin
                            term_bad_next = 1'b1;
                            phase_next    = PH_SKIP;
                        end
                    end
                    PH_AFTERCR:
                    begin
                        term_bad_next = 1'b1;
                        phase_next    = PH_SKIP;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end

        res.invalid_run   = run_next;
        res.garbage_alarm = (run_next > limit_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg  <= nsc_pkg::TIMEOUT_RESET;
            limit_reg    <= nsc_pkg::GARBAGE_RESET;
            phase_reg    <= PH_WAIT;
            xor_reg      <= 8'd0;
            first_c_reg  <= 1'b0;
            mismatch_reg <= 1'b0;
            term_bad_reg <= 1'b0;
            run_reg      <= 8'd0;
            elapsed_reg  <= 17'd0;
            seen_reg     <= 1'b0;
            fired_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == nsc_pkg::REG_TIMEOUT_TICKS)
                timeout_reg <= cfg_data[15:0];
            if (cfg_valid && cfg_index == nsc_pkg::REG_GARBAGE_LIMIT)
                limit_reg <= cfg_data[7:0];
            phase_reg    <= phase_next;
            xor_reg      <= xor_next;
            first_c_reg  <= first_c_next;
            mismatch_reg <= mismatch_next;
            term_bad_reg <= term_bad_next;
            run_reg      <= run_next;
            elapsed_reg  <= elapsed_next;
            seen_reg     <= seen_next;
            fired_reg    <= fired_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/nmea_sentence_checker.sv =====
// Top level of the NMEA sentence checker: front classifier, middle queue, back end, result queue.
// Depends on nsc_pkg, nsc_front, nsc_queue and nsc_back.
//
//   channel   handshake          payload
//   input     push / full        item   (nsc_pkg::in_word_t)
//   result    empty / pop        result (nsc_pkg::out_word_t)
//   config    cfg_valid/ready    cfg_index, cfg_data
//
// One word a cycle sustained while the result queue is not full; a word is registered in the
// middle queue, the back end handles the queue head combinationally, and a line end or a firing
// tick writes its result into the result queue, from which it can be popped.
// The back end stalls only when the result queue is full; the front keeps taking words
// until the middle queue fills.
// Reset clears both queues, the line state, counters, and loads register defaults.
`default_nettype none

module nmea_sentence_checker #(
    parameter int unsigned QueueDepth = nsc_pkg::QUEUE_DEPTH
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              push,
    output logic                             full,
    input  wire nsc_pkg::in_word_t           item,
    output logic                             empty,
    input  wire                              pop,
    output nsc_pkg::out_word_t               result,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [nsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire [nsc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int unsigned ClsW = $bits(nsc_pkg::cls_word_t);
    localparam int unsigned OutW = $bits(nsc_pkg::out_word_t);

    nsc_pkg::cls_word_t cls_in;
    nsc_pkg::cls_word_t cls_head;
    logic [ClsW-1:0]    cls_head_bits;
    logic               mid_empty;
    logic               out_full;
    logic               take;
    logic               res_valid;
    nsc_pkg::out_word_t res;
    logic [OutW-1:0]    result_bits;

    assign cfg_ready = 1'b1;

    nsc_front u_front (
        .item (item),
        .cls  (cls_in)
    );

    nsc_queue #(
        .Width (ClsW),
        .Depth (QueueDepth)
    ) u_mid_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cls_in),
        .full    (full),
        .rd_en   (take),
        .rd_data (cls_head_bits),
        .empty   (mid_empty)
    );

    assign cls_head = nsc_pkg::cls_word_t'(cls_head_bits);
    assign take     = !mid_empty && !out_full;

    nsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .cls       (cls_head),
        .res_valid (res_valid),
        .res       (res)
    );

    nsc_queue #(
        .Width (OutW),
        .Depth (QueueDepth)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (result_bits),
        .empty   (empty)
    );

    assign result = nsc_pkg::out_word_t'(result_bits);

endmodule

`default_nettype wire

// ===== src/nsc_checker.sv =====
// Port-level checks for the sentence checker, bound to the top level.
// Depends on nsc_pkg and nmea_sentence_checker.
`default_nettype none

module nsc_checker (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    empty,
    input  wire                    pop,
    input  wire nsc_pkg::out_word_t result
);

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result word changed or vanished");

    a_timeout_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.result_kind == nsc_pkg::KIND_TIMEOUT) |->
        (result.line_status == nsc_pkg::ST_OK && !result.compass_sentence &&
         result.computed_checksum == 8'd0))
        else $error("timeout word carries line fields");

    a_compass_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.compass_sentence) |->
        (result.line_status == nsc_pkg::ST_OK && result.invalid_run == 8'd0))
        else $error("compass flag on an invalid line");

    a_no_dollar_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.result_kind == nsc_pkg::KIND_LINE &&
         result.line_status == nsc_pkg::ST_NO_DOLLAR) |->
        (result.computed_checksum == 8'd0 && result.invalid_run != 8'd0))
        else $error("line without dollar reports a checksum or zero run");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.line_status <= nsc_pkg::ST_BAD_TERM))
        else $error("status code out of range");

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

`default_nettype wire
